@@ sv/lab_pkg.sv @@
package lab_pkg;

  // Q2.14 unit value
  localparam int OneQ14 = 16384;
  // Pipeline shape of one normalizer
  localparam int SqrtSteps = 32;
  localparam int DivSteps = 15;

  typedef struct packed {
    logic signed [31:0] source_x;
    logic signed [31:0] source_y;
    logic signed [31:0] source_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
  } lab_in_t;

  typedef struct packed {
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic signed [15:0] right_z;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
    logic signed [15:0] forward_x;
    logic signed [15:0] forward_y;
    logic signed [15:0] forward_z;
    logic               degenerate;
  } lab_out_t;

  // Values that ride along with a vector through a normalizer
  typedef struct packed {
    logic signed [15:0] fx;
    logic signed [15:0] fy;
    logic signed [15:0] fz;
    logic signed [15:0] rx;
    logic signed [15:0] ry;
    logic signed [15:0] rz;
    logic               deg;
  } lab_side_t;

  typedef struct packed {
    logic signed [33:0] cx;
    logic signed [33:0] cy;
    logic signed [33:0] cz;
    lab_side_t          side;
  } lab_nin_t;

  typedef struct packed {
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic               zero;
    lab_side_t          side;
  } lab_nout_t;

  typedef struct packed {
    lab_side_t  side;
    logic [2:0] sgn;
    logic       zero;
  } lab_ctx_t;

endpackage

@@ sv/lab_norm.sv @@
module lab_norm import lab_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  lab_nin_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output lab_nout_t out_data_o
);

  localparam int NSt = 8 + SqrtSteps + DivSteps;
  localparam int DivBase = 6 + SqrtSteps;

  logic [NSt-1:0] v_q;
  logic [NSt:0]   en;
  logic [NSt:0]   vin;

  assign en[NSt] = out_ready_i;
  assign vin = {v_q, in_valid_i};

  for (genvar k = 0; k < NSt; k++) begin : g_en
    assign en[k] = !v_q[k] || en[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NSt; k++) begin
        if (en[k]) v_q[k] <= vin[k];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NSt-1];

  // stage 0: input register
  logic signed [33:0] a_c_q [3];
  lab_side_t          a_side_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      a_c_q[0] <= in_data_i.cx;
      a_c_q[1] <= in_data_i.cy;
      a_c_q[2] <= in_data_i.cz;
      a_side_q <= in_data_i.side;
    end
  end

  // stage 1: magnitudes and largest magnitude
  logic [32:0] b_mag_d [3];
  logic [32:0] b_mx_d;
  lab_ctx_t    b_ctx_d;
  logic [32:0] b_mag_q [3];
  logic [32:0] b_mx_q;
  lab_ctx_t    b_ctx_q;

  always_comb begin
    logic signed [33:0] abs_v;
    b_ctx_d      = '0;
    b_ctx_d.side = a_side_q;
    for (int i = 0; i < 3; i++) begin
      abs_v = a_c_q[i][33] ? -a_c_q[i] : a_c_q[i];
      b_mag_d[i] = abs_v[32:0];
      b_ctx_d.sgn[i] = a_c_q[i][33];
    end
    b_mx_d = b_mag_d[0];
    if (b_mag_d[1] > b_mx_d) b_mx_d = b_mag_d[1];
    if (b_mag_d[2] > b_mx_d) b_mx_d = b_mag_d[2];
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      b_mag_q <= b_mag_d;
      b_mx_q  <= b_mx_d;
      b_ctx_q <= b_ctx_d;
    end
  end

  // stage 2: shift that brings the largest magnitude to [2^29, 2^30)
  logic [32:0] c_mag_q [3];
  logic        c_right_d, c_right_q;
  logic [4:0]  c_sh_d, c_sh_q;
  lab_ctx_t    c_ctx_d, c_ctx_q;

  always_comb begin
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 33; i++) begin
      if (b_mx_q[i]) p = 6'(i);
    end
    if (p >= 6'd30) begin
      c_right_d = 1'b1;
      c_sh_d    = 5'(p - 6'd29);
    end else begin
      c_right_d = 1'b0;
      c_sh_d    = 5'(6'd29 - p);
    end
    c_ctx_d      = b_ctx_q;
    c_ctx_d.zero = (b_mx_q == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      c_mag_q   <= b_mag_q;
      c_right_q <= c_right_d;
      c_sh_q    <= c_sh_d;
      c_ctx_q   <= c_ctx_d;
    end
  end

  // stage 3: shift
  logic [29:0] d_m_d [3];
  logic [29:0] d_m_q [3];
  lab_ctx_t    d_ctx_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_m_d[i] = c_right_q ? 30'(c_mag_q[i] >> c_sh_q) : 30'(c_mag_q[i] << c_sh_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      d_m_q   <= d_m_d;
      d_ctx_q <= c_ctx_q;
    end
  end

  // stage 4: squares
  logic [59:0] e_sq_q [3];
  logic [29:0] e_m_q [3];
  lab_ctx_t    e_ctx_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      for (int i = 0; i < 3; i++) begin
        e_sq_q[i] <= 60'(d_m_q[i]) * 60'(d_m_q[i]);
      end
      e_m_q   <= d_m_q;
      e_ctx_q <= d_ctx_q;
    end
  end

  // stage 5 and on: integer square root, one result bit per stage
  logic [63:0] sq_n_q   [SqrtSteps+1];
  logic [63:0] sq_res_q [SqrtSteps+1];
  logic [29:0] sq_m_q   [SqrtSteps+1][3];
  lab_ctx_t    sq_ctx_q [SqrtSteps+1];

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      sq_n_q[0]   <= 64'(e_sq_q[0]) + 64'(e_sq_q[1]) + 64'(e_sq_q[2]);
      sq_res_q[0] <= '0;
      sq_m_q[0]   <= e_m_q;
      sq_ctx_q[0] <= e_ctx_q;
    end
  end

  for (genvar e = 1; e <= SqrtSteps; e++) begin : g_sqrt
    localparam int unsigned Sh = 2 * (SqrtSteps - e);
    localparam logic [63:0] Bit = 64'(1) << Sh;
    logic [63:0] n_d, res_d;

    always_comb begin
      logic [63:0] t;
      t = sq_res_q[e-1] + Bit;
      if (sq_n_q[e-1] >= t) begin
        n_d   = sq_n_q[e-1] - t;
        res_d = (sq_res_q[e-1] >> 1) + Bit;
      end else begin
        n_d   = sq_n_q[e-1];
        res_d = sq_res_q[e-1] >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[5+e]) begin
        sq_n_q[e]   <= n_d;
        sq_res_q[e] <= res_d;
        sq_m_q[e]   <= sq_m_q[e-1];
        sq_ctx_q[e] <= sq_ctx_q[e-1];
      end
    end
  end

  // division: q = (m*2^15 + L) / (2L), restoring, one quotient bit per stage
  logic [46:0] dv_r_q   [DivSteps+1][3];
  logic [14:0] dv_q_q   [DivSteps+1][3];
  logic [32:0] dv_d_q   [DivSteps+1];
  lab_ctx_t    dv_ctx_q [DivSteps+1];

  always_ff @(posedge clk_i) begin
    if (en[DivBase]) begin
      for (int i = 0; i < 3; i++) begin
        dv_r_q[0][i] <= 47'({sq_m_q[SqrtSteps][i], 15'b0}) +
                        47'(sq_res_q[SqrtSteps][31:0]);
        dv_q_q[0][i] <= '0;
      end
      dv_d_q[0]   <= {sq_res_q[SqrtSteps][31:0], 1'b0};
      dv_ctx_q[0] <= sq_ctx_q[SqrtSteps];
    end
  end

  for (genvar e = 1; e <= DivSteps; e++) begin : g_div
    localparam int unsigned K = DivSteps - e;
    logic [46:0] r_d [3];
    logic [14:0] q_d [3];

    always_comb begin
      logic [47:0] dsh;
      dsh = 48'(dv_d_q[e-1]) << K;
      for (int i = 0; i < 3; i++) begin
        if ({1'b0, dv_r_q[e-1][i]} >= dsh) begin
          r_d[i] = 47'({1'b0, dv_r_q[e-1][i]} - dsh);
          q_d[i] = {dv_q_q[e-1][i][13:0], 1'b1};
        end else begin
          r_d[i] = dv_r_q[e-1][i];
          q_d[i] = {dv_q_q[e-1][i][13:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[DivBase+e]) begin
        dv_r_q[e]   <= r_d;
        dv_q_q[e]   <= q_d;
        dv_d_q[e]   <= dv_d_q[e-1];
        dv_ctx_q[e] <= dv_ctx_q[e-1];
      end
    end
  end

  // output stage: sign back, zero vector forced to zero
  logic signed [15:0] o_v_d [3];
  lab_nout_t          out_q;

  always_comb begin
    logic signed [15:0] qs;
    for (int i = 0; i < 3; i++) begin
      qs = $signed({1'b0, dv_q_q[DivSteps][i]});
      if (dv_ctx_q[DivSteps].zero) begin
        o_v_d[i] = '0;
      end else begin
        o_v_d[i] = dv_ctx_q[DivSteps].sgn[i] ? -qs : qs;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NSt-1]) begin
      out_q.qx   <= o_v_d[0];
      out_q.qy   <= o_v_d[1];
      out_q.qz   <= o_v_d[2];
      out_q.zero <= dv_ctx_q[DivSteps].zero;
      out_q.side <= dv_ctx_q[DivSteps].side;
    end
  end

  assign out_data_o = out_q;

endmodule

@@ sv/lab_cross.sv @@
module lab_cross import lab_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  lab_nout_t in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output lab_nin_t  out_data_o
);

  // up = forward x right; in_data_i carries right, side carries forward
  logic [1:0] v_q;
  logic [2:0] en;
  logic [2:0] vin;

  assign en[2] = out_ready_i;
  assign en[1] = !v_q[1] || en[2];
  assign en[0] = !v_q[0] || en[1];
  assign vin = {v_q, in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < 2; k++) begin
        if (en[k]) v_q[k] <= vin[k];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[1];

  logic signed [31:0] p_q [6];
  lab_side_t          side_d;
  lab_side_t          side_q;
  lab_nin_t           out_q;

  always_comb begin
    side_d     = in_data_i.side;
    side_d.rx  = in_data_i.qx;
    side_d.ry  = in_data_i.qy;
    side_d.rz  = in_data_i.qz;
    side_d.deg = in_data_i.side.deg | in_data_i.zero;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      p_q[0] <= 32'(in_data_i.side.fy) * 32'(in_data_i.qz);
      p_q[1] <= 32'(in_data_i.side.fz) * 32'(in_data_i.qy);
      p_q[2] <= 32'(in_data_i.side.fz) * 32'(in_data_i.qx);
      p_q[3] <= 32'(in_data_i.side.fx) * 32'(in_data_i.qz);
      p_q[4] <= 32'(in_data_i.side.fx) * 32'(in_data_i.qy);
      p_q[5] <= 32'(in_data_i.side.fy) * 32'(in_data_i.qx);
      side_q <= side_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      out_q.cx   <= 34'(p_q[0]) - 34'(p_q[1]);
      out_q.cy   <= 34'(p_q[2]) - 34'(p_q[3]);
      out_q.cz   <= 34'(p_q[4]) - 34'(p_q[5]);
      out_q.side <= side_q;
    end
  end

  assign out_data_o = out_q;

endmodule

@@ sv/look_at_basis_top.sv @@
// channel  direction  handshake                  payload
// in       input      in_valid_i / in_ready_o    in_data_i  (lab_in_t, Q16.16 positions)
// out      output     out_valid_o / out_ready_i  out_data_o (lab_out_t, Q2.14 axes, flag)
//
// One item per cycle sustained while out_ready_i stays high; three normalizers of 55 stages
// each plus a 2-stage cross product unit. The 32-step square root and the 15-step
// divider inside each normalizer set the depth.
// Reset clears only the stage valid bits; payload registers are not reset.
// A stall holds each occupied stage; empty stages keep filling, so bubbles close up.
module look_at_basis_top import lab_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  lab_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output lab_out_t out_data_o
);

  lab_nin_t  n0_in, n1_in, n2_in;
  lab_nout_t n0_out, n1_out, n2_out;
  logic      n0_ov, n1_iv, n1_ir, n1_ov, cr_ir, cr_ov, n2_ir, n2_ov;

  // forward = target - source
  always_comb begin
    n0_in      = '0;
    n0_in.cx   = 34'(in_data_i.target_x) - 34'(in_data_i.source_x);
    n0_in.cy   = 34'(in_data_i.target_y) - 34'(in_data_i.source_y);
    n0_in.cz   = 34'(in_data_i.target_z) - 34'(in_data_i.source_z);
  end

  lab_norm u_norm_fwd (
    .clk_i, .rst_ni,
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (n0_in),
    .out_valid_o (n0_ov),
    .out_ready_i (n1_ir),
    .out_data_o  (n0_out)
  );

  // right = (0,1,0) x forward = (fz, 0, -fx)
  always_comb begin
    n1_in          = '0;
    n1_in.cx       = 34'(n0_out.qz);
    n1_in.cz       = -34'(n0_out.qx);
    n1_in.side.fx  = n0_out.qx;
    n1_in.side.fy  = n0_out.qy;
    n1_in.side.fz  = n0_out.qz;
    n1_in.side.deg = n0_out.zero;
  end

  assign n1_iv = n0_ov;

  lab_norm u_norm_right (
    .clk_i, .rst_ni,
    .in_valid_i  (n1_iv),
    .in_ready_o  (n1_ir),
    .in_data_i   (n1_in),
    .out_valid_o (n1_ov),
    .out_ready_i (cr_ir),
    .out_data_o  (n1_out)
  );

  lab_cross u_cross (
    .clk_i, .rst_ni,
    .in_valid_i  (n1_ov),
    .in_ready_o  (cr_ir),
    .in_data_i   (n1_out),
    .out_valid_o (cr_ov),
    .out_ready_i (n2_ir),
    .out_data_o  (n2_in)
  );

  lab_norm u_norm_up (
    .clk_i, .rst_ni,
    .in_valid_i  (cr_ov),
    .in_ready_o  (n2_ir),
    .in_data_i   (n2_in),
    .out_valid_o (n2_ov),
    .out_ready_i (out_ready_i),
    .out_data_o  (n2_out)
  );

  assign out_valid_o = n2_ov;

  always_comb begin
    out_data_o.right_x    = n2_out.side.rx;
    out_data_o.right_y    = n2_out.side.ry;
    out_data_o.right_z    = n2_out.side.rz;
    out_data_o.up_x       = n2_out.qx;
    out_data_o.up_y       = n2_out.qy;
    out_data_o.up_z       = n2_out.qz;
    out_data_o.forward_x  = n2_out.side.fx;
    out_data_o.forward_y  = n2_out.side.fy;
    out_data_o.forward_z  = n2_out.side.fz;
    out_data_o.degenerate = n2_out.side.deg | n2_out.zero;
  end

endmodule

@@ sv/lab_chk.sv @@
module lab_chk import lab_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input lab_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input lab_out_t out_data_o
);

  // a stalled input transfer holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("input changed while stalled");

  // a stalled result transfer holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // right axis has no vertical component
  a_right_flat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.right_y == 16'sd0)
    else $error("right_y nonzero");

  // any degenerate case leaves up at zero
  a_deg_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.degenerate |->
      out_data_o.up_x == 16'sd0 && out_data_o.up_y == 16'sd0 && out_data_o.up_z == 16'sd0)
    else $error("degenerate with nonzero up");

  // a full basis has a nonzero forward axis
  a_fwd_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.degenerate |->
      out_data_o.forward_x != 16'sd0 || out_data_o.forward_y != 16'sd0 ||
      out_data_o.forward_z != 16'sd0)
    else $error("zero forward without degenerate");

endmodule

bind look_at_basis_top lab_chk u_lab_chk (.*);

@@ test/look_at_basis_top_test.sv @@
`timescale 1ns / 1ps

module look_at_basis_top_test;
  import lab_pkg::*;

  localparam int Latency = 167;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  lab_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  lab_out_t out_data;

  look_at_basis_top u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  lab_out_t basis_q[$];
  int       mismatch_cnt = 0;
  bit       calm_mode = 0;
  int       hold_cycles = 0;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // exact fixed point normalization to Q2.14; returns 1 on zero length
  function automatic bit norm_vec(input longint v[3], output logic signed [15:0] q[3]);
    longint unsigned m[3];
    longint unsigned mx, sum, len, res, bit_v, n, d;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      for (int i = 0; i < 3; i++) q[i] = '0;
      return 1'b1;
    end
    while (mx >= 64'd1 << 30) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    while (mx < 64'd1 << 29) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    n = sum;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > n) bit_v >>= 2;
    while (bit_v != 0) begin
      if (n >= res + bit_v) begin
        n -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    len = res;
    for (int i = 0; i < 3; i++) begin
      d = (2 * m[i] * OneQ14 + len) / (2 * len);
      q[i] = (v[i] < 0) ? -16'(d) : 16'(d);
    end
    return 1'b0;
  endfunction

  function automatic lab_out_t predict_basis(input lab_in_t a);
    lab_out_t r;
    longint d[3], rc[3], uc[3];
    logic signed [15:0] f[3], rt[3], u[3];
    bit deg;
    d[0] = longint'(a.target_x) - longint'(a.source_x);
    d[1] = longint'(a.target_y) - longint'(a.source_y);
    d[2] = longint'(a.target_z) - longint'(a.source_z);
    deg = norm_vec(d, f);
    rc[0] = f[2];
    rc[1] = 0;
    rc[2] = -longint'(f[0]);
    deg |= norm_vec(rc, rt);
    uc[0] = longint'(f[1]) * rt[2] - longint'(f[2]) * rt[1];
    uc[1] = longint'(f[2]) * rt[0] - longint'(f[0]) * rt[2];
    uc[2] = longint'(f[0]) * rt[1] - longint'(f[1]) * rt[0];
    deg |= norm_vec(uc, u);
    r.right_x = rt[0];
    r.right_y = rt[1];
    r.right_z = rt[2];
    r.up_x = u[0];
    r.up_y = u[1];
    r.up_z = u[2];
    r.forward_x = f[0];
    r.forward_y = f[1];
    r.forward_z = f[2];
    r.degenerate = deg;
    return r;
  endfunction

  // valid stays up after a transfer; the next item or an idle cycle takes it down
  task automatic send_item(input lab_in_t a);
    while (!calm_mode && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= a;
    basis_q.push_back(predict_basis(a));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic lab_in_t make_item(input int sx, sy, sz, tx, ty, tz);
    lab_in_t a;
    a.source_x = sx;
    a.source_y = sy;
    a.source_z = sz;
    a.target_x = tx;
    a.target_y = ty;
    a.target_z = tz;
    return a;
  endfunction

  function automatic int rand_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(2) == 0 ? 32'sh8000_0000 : 32'sh7fff_ffff;
      2: return int'($urandom_range(16)) - 8;
      3: return int'($urandom_range(32'h20000)) - 32'h10000;
      default: return int'($urandom_range(32'h1000000)) - 32'h800000;
    endcase
  endfunction

  // checker: compares every output transfer with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (basis_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result %h", out_data);
      end else begin
        lab_out_t e;
        e = basis_q.pop_front();
        if (out_data !== e) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: expected %h actual %h", e, out_data);
        end
      end
    end
  end

  // output stall driver
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm_mode ? 1'b1 : ($urandom_range(99) >= 18);
    end
  end

  task automatic test_directed();
    int mx, mn;
    mx = 32'sh7fff_ffff;
    mn = 32'sh8000_0000;
    send_item(make_item(0, 0, 0, 0, 0, 0));
    send_item(make_item(5, -7, 9, 5, -7, 9));
    send_item(make_item(0, 0, 0, 0, 65536, 0));
    send_item(make_item(0, 0, 0, 0, -1, 0));
    send_item(make_item(mn, mn, mn, mx, mx, mx));
    send_item(make_item(mx, mx, mx, mn, mn, mn));
    send_item(make_item(mn, 0, mx, mx, 0, mn));
    send_item(make_item(0, 0, 0, 1, 0, 0));
    send_item(make_item(0, 0, 0, 0, 0, 1));
    send_item(make_item(0, 0, 0, 0, 0, -1));
    send_item(make_item(0, 0, 0, 1, 1, 1));
    send_item(make_item(0, 0, 0, 65536, 0, 65536));
    send_item(make_item(-1, -1, -1, 0, 0, 0));
    send_item(make_item(mx, mn, mx, mn, mx, mn));
    send_item(make_item(0, 0, 0, 1, mx, 0));
    send_item(make_item(0, 0, 0, 3, 4, 0));
  endtask

  task automatic test_random(input int cnt);
    int c[6];
    for (int k = 0; k < cnt; k++) begin
      for (int i = 0; i < 6; i++) c[i] = rand_coord();
      // some items share source and target, or point straight up or down
      case ($urandom_range(9))
        0: begin c[3] = c[0]; c[4] = c[1]; c[5] = c[2]; end
        1: begin c[3] = c[0]; c[5] = c[2]; end
        default: ;
      endcase
      send_item(make_item(c[0], c[1], c[2], c[3], c[4], c[5]));
    end
  endtask

  task automatic test_back_pressure();
    hold_cycles = 400;
    test_random(300);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (basis_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_no_idle();
    calm_mode = 1;
    test_random(400);
    calm_mode = 0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(600);
    test_back_pressure();
    wait_drained();
    test_no_idle();
    test_random(600);
    wait_drained();
    repeat (Latency + 20) @(posedge clk);
    if (mismatch_cnt == 0 && basis_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
